[rtl/mmu_tlb_fifo_paging_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the paging MMU
// ---------------------------------------------------------------------------
`ifndef MMU_TLB_FIFO_PAGING_ASSERT_SVH
`define MMU_TLB_FIFO_PAGING_ASSERT_SVH

// a |-> b checked on clk, off in reset
`define MTP_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("mmu check failed");

// a |=> b checked on clk, off in reset
`define MTP_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("mmu check failed");

`endif

[rtl/mtp_pkg.sv]
// ---------------------------------------------------------------------------
// mtp_pkg: shared types and constants of the paging MMU
// ---------------------------------------------------------------------------
package mtp_pkg;

  localparam int TLB_ENTRIES_D  = 16;
  localparam int PAGE_ENTRIES_D = 256;
  localparam int MAX_FRAMES_D   = 256;

  localparam logic [1:0] OUT_TLB_HIT  = 2'd0;
  localparam logic [1:0] OUT_PT_HIT   = 2'd1;
  localparam logic [1:0] OUT_FREE     = 2'd2;
  localparam logic [1:0] OUT_REPLACED = 2'd3;

  localparam logic CFG_OFFSET_BITS  = 1'b0;
  localparam logic CFG_TOTAL_FRAMES = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch input, look up TLB / memories
    logic commit;    // update state, load output register
  } mtp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;  // output register stays full this cycle
  } mtp_sts_t;

endpackage

[rtl/mtp_ram.sv]
// ---------------------------------------------------------------------------
// mtp_ram: generic single-write, registered-read RAM
// ---------------------------------------------------------------------------
module mtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mtp_ctrl.sv]
// ---------------------------------------------------------------------------
// mtp_ctrl: request sequencer, lookup then update
// ---------------------------------------------------------------------------
module mtp_ctrl
  import mtp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  mtp_sts_t sts,
  output mtp_cmd_t cmd
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_UPDATE = 1'b1;

  logic state_r, state_nxt;

  always_comb begin
    in_tready   = (state_r == ST_IDLE);
    cmd.capture = in_tready && in_tvalid;
    cmd.commit  = (state_r == ST_UPDATE) && !sts.out_busy;
    state_nxt   = state_r;
    case (state_r)
      ST_IDLE:   if (cmd.capture) state_nxt = ST_UPDATE;
      ST_UPDATE: if (cmd.commit) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/mtp_dp.sv]
// ---------------------------------------------------------------------------
// mtp_dp: TLB, page table, frame allocator and output register
// ---------------------------------------------------------------------------
module mtp_dp
  import mtp_pkg::*;
#(
  parameter int TLB_ENTRIES  = TLB_ENTRIES_D,
  parameter int PAGE_ENTRIES = PAGE_ENTRIES_D,
  parameter int MAX_FRAMES   = MAX_FRAMES_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mtp_cmd_t    cmd,
  output mtp_sts_t    sts,
  input  logic [15:0] in_addr,
  input  logic [3:0]  offset_bits,
  input  logic [8:0]  total_frames,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] o_phys,
  output logic [7:0]  o_frame,
  output logic [7:0]  o_page,
  output logic [1:0]  o_outcome,
  output logic        o_ev_valid,
  output logic [7:0]  o_ev_page
);

  localparam int TW = $clog2(TLB_ENTRIES);
  localparam int PW = $clog2(PAGE_ENTRIES);
  localparam int FW = $clog2(MAX_FRAMES);

  logic [TLB_ENTRIES-1:0] tlb_valid_r;
  logic [TLB_ENTRIES-1:0] tlb_valid_nxt;
  logic [7:0]             tlb_page_r  [TLB_ENTRIES];
  logic [7:0]             tlb_frame_r [TLB_ENTRIES];
  logic [TW-1:0]          tlb_ptr_r;
  logic [PAGE_ENTRIES-1:0] pv_r;
  logic [PAGE_ENTRIES-1:0] pv_nxt;
  logic [FW:0]            next_frame_r;
  logic [FW:0]            fill_cnt_r;   // frames below this have an owner entry
  logic                   all_used_r;

  logic [3:0]  ob_r;
  logic [7:0]  page_r;
  logic [15:0] addr_r;
  logic        tlb_hit_r;
  logic [7:0]  tlb_hit_frame_r;

  logic [7:0]  pf_rdata;
  logic [7:0]  own_rdata;

  // capture-side lookup
  logic [3:0]  ob_c;
  logic [7:0]  page_c;
  logic        hit_c;
  logic [7:0]  hit_frame_c;
  logic [FW:0] frames_c;
  logic [FW:0] nf_c;

  always_comb begin
    ob_c   = (offset_bits < 4'd8) ? 4'd8 : offset_bits;
    page_c = 8'((in_addr >> ob_c) & 16'(PAGE_ENTRIES - 1));
    hit_c  = 1'b0;
    hit_frame_c = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid_r[i] && tlb_page_r[i] == page_c) begin
        hit_c       = 1'b1;
        hit_frame_c = tlb_frame_r[i];
      end
    end
    if (total_frames == 9'd0) begin
      frames_c = (FW + 1)'(1);
    end else if (total_frames > 9'(MAX_FRAMES)) begin
      frames_c = (FW + 1)'(MAX_FRAMES);
    end else begin
      frames_c = (FW + 1)'(total_frames);
    end
  end

  logic [FW:0] frames_r;
  always_comb nf_c = (next_frame_r >= frames_r) ? '0 : next_frame_r;

  // reads stay on the captured request while the update waits
  logic [PW-1:0] pf_raddr;
  always_comb pf_raddr = cmd.capture ? page_c[PW-1:0] : page_r[PW-1:0];

  mtp_ram #(.WIDTH(8), .DEPTH(PAGE_ENTRIES)) u_pf (
    .clk(clk), .we(cmd.commit && !tlb_hit_r && !pv_r[page_r[PW-1:0]]),
    .waddr(page_r[PW-1:0]), .wdata(8'(nf_c)),
    .raddr(pf_raddr), .rdata(pf_rdata)
  );

  // owner memory, read at the frame the next fault will use
  logic [FW-1:0] own_raddr;
  always_comb begin
    if (cmd.capture) begin
      own_raddr = (next_frame_r >= frames_c) ? '0 : FW'(next_frame_r);
    end else begin
      own_raddr = FW'(nf_c);
    end
  end

  mtp_ram #(.WIDTH(8), .DEPTH(MAX_FRAMES)) u_own (
    .clk(clk), .we(cmd.commit && !tlb_hit_r && !pv_r[page_r[PW-1:0]]),
    .waddr(FW'(nf_c)), .wdata(page_r),
    .raddr(own_raddr), .rdata(own_rdata)
  );

  // commit-side decision
  // a valid owner page is always mapped to the frame that lists it
  logic          fault;
  logic [7:0]    owner;
  logic          own_ok;
  logic          ev;
  logic [7:0]    frame_c;
  logic [1:0]    outc;
  logic          do_fill;

  always_comb begin
    fault   = !tlb_hit_r && !pv_r[page_r[PW-1:0]];
    owner   = 8'(own_rdata & 8'(PAGE_ENTRIES - 1));
    own_ok  = (nf_c < fill_cnt_r);
    ev      = fault && all_used_r && own_ok && pv_r[owner[PW-1:0]];
    if (tlb_hit_r) begin
      frame_c = tlb_hit_frame_r;
      outc    = OUT_TLB_HIT;
    end else if (!fault) begin
      frame_c = pf_rdata;
      outc    = OUT_PT_HIT;
    end else begin
      frame_c = 8'(nf_c);
      outc    = all_used_r ? OUT_REPLACED : OUT_FREE;
    end
    do_fill = !tlb_hit_r;
  end

  always_comb begin
    pv_nxt        = pv_r;
    tlb_valid_nxt = tlb_valid_r;
    if (cmd.commit) begin
      if (fault) begin
        if (ev) pv_nxt[owner[PW-1:0]] = 1'b0;
        pv_nxt[page_r[PW-1:0]] = 1'b1;
      end
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (ev && tlb_page_r[i] == owner) tlb_valid_nxt[i] = 1'b0;
      end
      if (do_fill) tlb_valid_nxt[tlb_ptr_r] = 1'b1;
    end
  end

  assign sts.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ob_r            <= ob_c;
      page_r          <= page_c;
      addr_r          <= in_addr;
      tlb_hit_r       <= hit_c;
      tlb_hit_frame_r <= hit_frame_c;
      frames_r        <= frames_c;
    end
    if (cmd.commit) begin
      o_phys     <= 16'((16'(frame_c) << ob_r) + (addr_r & 16'((17'd1 << ob_r) - 17'd1)));
      o_frame    <= frame_c;
      o_page     <= page_r;
      o_outcome  <= outc;
      o_ev_valid <= ev;
      o_ev_page  <= ev ? owner : 8'd0;
      if (do_fill) begin
        tlb_page_r[tlb_ptr_r]  <= page_r;
        tlb_frame_r[tlb_ptr_r] <= frame_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlb_valid_r  <= '0;
      tlb_ptr_r    <= '0;
      pv_r         <= '0;
      next_frame_r <= '0;
      fill_cnt_r   <= '0;
      all_used_r   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      tlb_valid_r <= tlb_valid_nxt;
      pv_r        <= pv_nxt;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        if (fault) begin
          if (nf_c >= fill_cnt_r) fill_cnt_r <= nf_c + 1'b1;
          if (!all_used_r) begin
            if (nf_c + 1'b1 >= frames_r) begin
              next_frame_r <= '0;
              all_used_r   <= 1'b1;
            end else begin
              next_frame_r <= nf_c + 1'b1;
            end
          end else begin
            next_frame_r <= (nf_c + 1'b1 >= frames_r) ? '0 : nf_c + 1'b1;
          end
        end
        if (do_fill) begin
          tlb_ptr_r <= TW'(tlb_ptr_r + 1'b1);
        end
      end
    end
  end

endmodule

[rtl/mmu_tlb_fifo_paging.sv]
// ---------------------------------------------------------------------------
// mmu_tlb_fifo_paging: paging MMU with TLB and FIFO frame replacement
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one logical address per request.
//   out_* : one translation result per request.
//   cfg_* : register 0 offset_bits, register 1 total_frames; write when idle.
// Timing: a request passes a lookup step, then an update step; the result is
//   in the output register after the update edge. in_tready returns right
//   after the update, so a new request is taken only once the last one has
//   finished its update; the spacing is set by the read-modify-write of the
//   page-table memory.
// Reset: TLB, page valid bits, frame pointer, frame fill count and output
//   cleared; registers return to offset_bits 8 and total_frames 128.
//   Page-frame and owner memories need no clearing.
// Stall: while out_tready is low the result holds; one more request can be
//   taken and waits in the update step until the output register frees.
// ---------------------------------------------------------------------------
module mmu_tlb_fifo_paging
  import mtp_pkg::*;
#(
  parameter int TLB_ENTRIES  = TLB_ENTRIES_D,
  parameter int PAGE_ENTRIES = PAGE_ENTRIES_D,
  parameter int MAX_FRAMES   = MAX_FRAMES_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // logical_address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // physical_address, frame_number, page_number,
                                  // outcome, evicted_valid, evicted_page, zero pad
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_wdata
);

  `include "mmu_tlb_fifo_paging_assert.svh"

  logic [3:0] offset_bits_r;
  logic [8:0] total_frames_r;
  mtp_cmd_t   cmd;
  mtp_sts_t   sts;
  logic [15:0] o_phys;
  logic [7:0]  o_frame, o_page, o_ev_page;
  logic [1:0]  o_outcome;
  logic        o_ev_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r  <= 4'd8;
      total_frames_r <= 9'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET_BITS:  offset_bits_r  <= cfg_wdata[3:0];
        CFG_TOTAL_FRAMES: total_frames_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mtp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .sts(sts), .cmd(cmd)
  );

  mtp_dp #(
    .TLB_ENTRIES(TLB_ENTRIES), .PAGE_ENTRIES(PAGE_ENTRIES), .MAX_FRAMES(MAX_FRAMES)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_addr(in_tdata),
    .offset_bits(offset_bits_r), .total_frames(total_frames_r),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .o_phys(o_phys), .o_frame(o_frame), .o_page(o_page), .o_outcome(o_outcome),
    .o_ev_valid(o_ev_valid), .o_ev_page(o_ev_page)
  );

  assign out_tdata = {5'd0, o_ev_page, o_ev_valid, o_outcome, o_page, o_frame, o_phys};

  `MTP_ASSERT_NXT(a_capture_blocks, cmd.capture, !in_tready)
  `MTP_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `MTP_ASSERT_IMP(a_ev_only_replace, out_tvalid && out_tdata[34],
                  out_tdata[33:32] == OUT_REPLACED)

endmodule

[verif/mtp_checker.sv]
// ----------------------------------------------------------------------------
// mtp_checker: translation predictor and result checker
// Watches the request, result and register write ports of the paging MMU,
// keeps its own TLB, page table and frame pointer, and compares each result
// field by field with the oldest predicted translation.
// ----------------------------------------------------------------------------
module mtp_checker
  import mtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  ev_page;
    logic        ev_valid;
    logic [1:0]  outcome;
    logic [7:0]  page;
    logic [7:0]  frame;
    logic [15:0] phys;
  } xlate_t;

  logic [3:0] offset_bits;
  logic [8:0] total_frames;
  logic       tlb_v [16];
  logic [7:0] tlb_pg [16];
  logic [7:0] tlb_fr [16];
  logic [3:0] tlb_ptr;
  logic       pt_v [256];
  logic [7:0] pt_fr [256];
  logic [7:0] owner [256];
  int         next_fr;
  logic       frames_used;
  xlate_t     expected_q[$];

  function automatic xlate_t translate(logic [15:0] addr);
    xlate_t r;
    int ob, frames, pg, fr, ow;
    logic hit;
    ob = (offset_bits < 4'd8) ? 8 : int'(offset_bits);
    frames = (total_frames == 9'd0) ? 1 :
             (total_frames > 9'd256 ? 256 : int'(total_frames));
    pg = int'((addr >> ob) & 16'h00FF);
    hit = 1'b0;
    fr = 0;
    r = '0;
    for (int i = 0; i < 16; i++)
      if (!hit && tlb_v[i] && tlb_pg[i] == pg) begin
        hit = 1'b1;
        fr = int'(tlb_fr[i]);
      end
    if (hit) begin
      r.outcome = OUT_TLB_HIT;
    end else if (pt_v[pg]) begin
      fr = int'(pt_fr[pg]);
      r.outcome = OUT_PT_HIT;
    end else begin
      if (next_fr >= frames) next_fr = 0;
      fr = next_fr;
      if (!frames_used) begin
        r.outcome = OUT_FREE;
        next_fr = fr + 1;
        if (next_fr >= frames) begin
          next_fr = 0;
          frames_used = 1'b1;
        end
      end else begin
        r.outcome = OUT_REPLACED;
        next_fr = (fr + 1) % frames;
        ow = int'(owner[fr]);
        if (pt_v[ow] && pt_fr[ow] == fr) begin
          r.ev_valid = 1'b1;
          r.ev_page = 8'(ow);
          pt_v[ow] = 1'b0;
          for (int i = 0; i < 16; i++)
            if (tlb_v[i] && tlb_pg[i] == ow) tlb_v[i] = 1'b0;
        end
      end
      pt_v[pg] = 1'b1;
      pt_fr[pg] = 8'(fr);
      owner[fr] = 8'(pg);
    end
    if (!hit) begin
      tlb_v[tlb_ptr] = 1'b1;
      tlb_pg[tlb_ptr] = 8'(pg);
      tlb_fr[tlb_ptr] = 8'(fr);
      tlb_ptr = tlb_ptr + 4'd1;
    end
    r.phys = 16'((fr << ob) + (addr & ((1 << ob) - 1)));
    r.frame = 8'(fr);
    r.page = 8'(pg);
    return r;
  endfunction

  always @(posedge clk) begin
    xlate_t got, want;
    if (!rst_n) begin
      offset_bits = 4'd8;
      total_frames = 9'd128;
      for (int i = 0; i < 16; i++) tlb_v[i] = 1'b0;
      for (int i = 0; i < 256; i++) pt_v[i] = 1'b0;
      tlb_ptr = '0;
      next_fr = 0;
      frames_used = 1'b0;
      expected_q.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_OFFSET_BITS) offset_bits = cfg_wdata[3:0];
        else total_frames = cfg_wdata;
      end
      if (in_tvalid && in_tready) expected_q.push_back(translate(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[42:0];
        result_count++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want || out_tdata[47:43] !== 5'd0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp phys %h fr %h pg %h oc %0d ev %b/%h, got phys %h fr %h pg %h oc %0d ev %b/%h",
                       want.phys, want.frame, want.page, want.outcome, want.ev_valid,
                       want.ev_page, got.phys, got.frame, got.page, got.outcome,
                       got.ev_valid, got.ev_page);
          end
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: paging MMU testbench
// Directed corner addresses and register settings, then random address
// streams localized to small working sets, across several offset widths and
// frame counts, with bursty requests and a stalling result receiver.
// ----------------------------------------------------------------------------
module tb;
  import mtp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        cfg_we;
  logic        cfg_index;
  logic [8:0]  cfg_wdata;
  int          fail_count, pending, result_count;
  int          idle_cycles;
  int          requests_sent;
  int          gap_left, burst_left;

  mmu_tlb_fifo_paging dut (.*);
  mtp_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_tready = 0;
    forever begin
      @(posedge clk);
      case ($urandom_range(0, 3))
        0: out_tready <= 1'b0;
        1: out_tready <= ($urandom_range(0, 9) == 0);
        default: out_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // in_tvalid stays high after an accept until the next request, a gap or
  // a register write replaces it
  task automatic send_addr(input logic [15:0] addr);
    if (burst_left == 0) begin
      gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
    end
    if (gap_left > 0) in_tvalid <= 1'b0;
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    in_tvalid <= 1'b1;
    in_tdata <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    requests_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] val);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    logic [15:0] base;
    base = 16'($urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) base = 16'($urandom);
      if ($urandom_range(0, 4) == 0) send_addr(16'($urandom));
      else send_addr(base ^ 16'($urandom_range(0, 16'h0FFF) << $urandom_range(0, 4)));
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    cfg_we = 0;
    cfg_index = CFG_OFFSET_BITS;
    cfg_wdata = 0;
    idle_cycles = 0;
    requests_sent = 0;
    gap_left = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // extremes, TLB and page-table hits, frames filling
    send_addr(16'h0000); send_addr(16'hFFFF); send_addr(16'h0012);
    send_addr(16'hFF00); send_addr(16'h5555); send_addr(16'hAAAA);
    // small offset width clamps to eight bits
    write_reg(CFG_OFFSET_BITS, 9'd0);
    send_addr(16'h1234); send_addr(16'h1234);
    // a single frame: constant replacement
    write_reg(CFG_TOTAL_FRAMES, 9'd0);
    send_addr(16'h0101); send_addr(16'h0202); send_addr(16'h0101);
    // widest offset, overflowing physical address
    write_reg(CFG_OFFSET_BITS, 9'd15);
    write_reg(CFG_TOTAL_FRAMES, 9'h1FF);
    send_addr(16'hFFFF); send_addr(16'h7FFF); send_addr(16'h8000);
    // duplicate TLB pages after an offset change
    write_reg(CFG_OFFSET_BITS, 9'd8);
    send_addr(16'h0001); send_addr(16'h0100); send_addr(16'h8001);
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_OFFSET_BITS, 9'($urandom_range(0, 15)));
      case (ph % 4)
        0: write_reg(CFG_TOTAL_FRAMES, 9'($urandom_range(1, 8)));
        1: write_reg(CFG_TOTAL_FRAMES, 9'd256);
        2: write_reg(CFG_TOTAL_FRAMES, 9'($urandom_range(0, 511)));
        default: write_reg(CFG_TOTAL_FRAMES, 9'($urandom_range(2, 40)));
      endcase
      random_phase(170);
    end
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d requests over ten register settings, %0d results checked",
             requests_sent, result_count);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
